// ===== rtl/krmv_pkg.sv =====
`timescale 1ns / 1ps
package krmv_pkg;
  localparam int unsigned NumSlots  = 4;
  localparam int unsigned MaxWorlds = 4;
  localparam int unsigned MaxCoords = 256;
  localparam int unsigned Depth     = MaxWorlds * MaxCoords;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned SlotW     = $clog2(MaxWorlds);
  localparam int unsigned CoordW    = $clog2(MaxCoords);
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned NW        = 25;
  localparam logic [47:0] VarMax    = 48'hFFFF_FFFF_FFFF;

  localparam logic [CfgIdxW-1:0] CfgWorldsInUse = 3'd4;

  typedef struct packed {
    logic [7:0]  world_key;
    logic [7:0]  coord_index;
    logic signed [31:0] sample_value;
    logic [23:0] earlier_samples;
  } in_word_t;

  typedef struct packed {
    logic        world_found;
    logic signed [31:0] mean_out;
    logic signed [31:0] deviation_out;
    logic [47:0] variance_out;
  } out_word_t;

  typedef struct packed {
    logic [31:0] mean;
    logic [31:0] dev;
    logic [47:0] var_v;
  } stat_t;

  // divider control
  typedef struct packed {
    logic        start;
    logic [48:0] num;
    logic [NW-1:0] den;
  } div_req_t;
endpackage

// ===== rtl/krmv_div.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider, unsigned 49-bit numerator, one quotient bit a cycle.
module krmv_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  krmv_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [48:0]       quo_o
);
  import krmv_pkg::*;
  logic [48:0] q_q, q_d;
  logic [NW:0] r_q, r_d;
  logic [NW-1:0] den_q;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [NW:0] tr;

  always_comb begin
    q_d = q_q; r_d = r_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    tr = {r_q[NW-1:0], q_q[48]};
    if (req_i.start) begin
      q_d = req_i.num; r_d = '0; cnt_d = 6'd49; busy_d = 1'b1;
    end else if (busy_q) begin
      if (tr >= {1'b0, den_q}) begin
        r_d = tr - {1'b0, den_q}; q_d = {q_q[47:0], 1'b1};
      end else begin
        r_d = tr; q_d = {q_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d;
    if (req_i.start) den_q <= req_i.den;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
endmodule

// ===== rtl/krmv_store.sv =====
`timescale 1ns / 1ps
// Statistics memory with a registered read and a clearing sweep after reset.
module krmv_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [krmv_pkg::AddrW-1:0] raddr_i,
  output krmv_pkg::stat_t       rdata_o,
  input  logic                  we_i,
  input  logic [krmv_pkg::AddrW-1:0] waddr_i,
  input  krmv_pkg::stat_t       wdata_i,
  output logic                  clearing_o
);
  import krmv_pkg::*;
  stat_t mem [Depth];
  logic [AddrW:0] clr_q;
  logic clearing;

  assign clearing   = !clr_q[AddrW];
  assign clearing_o = clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (clearing) clr_q <= clr_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (clearing) mem[clr_q[AddrW-1:0]] <= '0;
    else if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/keyed_running_mean_variance.sv =====
`timescale 1ns / 1ps
// A later sample of a known world runs two divider passes by N between accept
// and result; first samples and misses skip the divider and go on to the write.
// Throughput: one word at a time; the next word can be taken in the cycle after
// its result is loaded into the output register.
// A result held by the receiver keeps the block in its output state.
// Reset: asynchronous, active low; state, ids and count zero, then full store clear.
module keyed_running_mean_variance (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  krmv_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output krmv_pkg::out_word_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [krmv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [krmv_pkg::CfgDataW-1:0] cfg_data_i
);
  import krmv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_MDIV, S_MWAIT, S_SQ1, S_SQ2, S_VDIV, S_VWAIT, S_WRITE, S_OUT
  } state_e;

  state_e state_q;
  logic [7:0] slot_id_q [NumSlots];
  logic [2:0] in_use_q;
  in_word_t it_q;
  logic [SlotW-1:0] slot_q;
  logic found_q;
  stat_t old_q, new_q;
  logic signed [32:0] xm_q;
  logic signed [31:0] dev_s;
  logic [31:0] adev_q;
  logic [63:0] sq_q;
  logic [47:0] term_q;
  logic var_up_q;
  out_word_t out_q;
  logic out_v_q;

  stat_t rdata;
  logic clearing;
  div_req_t dreq;
  logic ddone;
  logic [48:0] dquo;
  logic [NW-1:0] n_val;
  logic [AddrW-1:0] addr;
  logic [AddrW-1:0] raddr;
  logic hit;
  logic [SlotW-1:0] hslot;
  logic [2:0] lim;

  assign n_val = {1'b0, it_q.earlier_samples} + NW'(1);
  assign addr  = {slot_q, it_q.coord_index[CoordW-1:0]};
  assign raddr = {hslot, it_q.coord_index[CoordW-1:0]};
  assign lim   = (in_use_q > 3'(MaxWorlds)) ? 3'(MaxWorlds) : in_use_q;

  always_comb begin
    hit = 1'b0; hslot = '0;
    for (int s = NumSlots - 1; s >= 0; s--) begin
      if (3'(s) < lim && slot_id_q[s] == it_q.world_key) begin
        hit = 1'b1; hslot = SlotW'(s);
      end
    end
  end

  krmv_store u_store (
    .clk_i, .rst_ni, .raddr_i(raddr), .rdata_o(rdata),
    .we_i(state_q == S_WRITE && found_q), .waddr_i(addr), .wdata_i(new_q),
    .clearing_o(clearing)
  );

  // mean division on |x-mean|, variance division on |term-old|
  logic signed [32:0] xm_w;
  logic [47:0] vdiff;
  assign xm_w  = 33'(it_q.sample_value) - 33'($signed(rdata.mean));
  assign vdiff = var_up_q ? term_q - old_q.var_v : old_q.var_v - term_q;

  always_comb begin
    dreq = '0;
    dreq.den = n_val;
    if (state_q == S_MDIV) begin
      dreq.start = 1'b1;
      dreq.num = 49'(xm_w[32] ? -xm_w : xm_w);
    end else if (state_q == S_VDIV) begin
      dreq.start = 1'b1;
      dreq.num = {1'b0, vdiff};
    end
  end

  krmv_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quo_o(dquo));

  // new mean = mean +/- q; stays in 32-bit range since it lies between mean and x
  logic signed [32:0] mean_w, dev_w;
  assign mean_w = xm_q[32] ? 33'($signed(old_q.mean)) - 33'(dquo[31:0])
                           : 33'($signed(old_q.mean)) + 33'(dquo[31:0]);
  assign dev_w  = 33'(it_q.sample_value) - mean_w;
  assign dev_s  = (dev_w > 33'sd2147483647) ? 32'sh7FFF_FFFF :
                  (dev_w < -33'sd2147483648) ? 32'sh8000_0000 : dev_w[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_v_q <= 1'b0; in_use_q <= '0;
      for (int s = 0; s < NumSlots; s++) slot_id_q[s] <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < CfgWorldsInUse) slot_id_q[cfg_idx_i[1:0]] <= cfg_data_i;
        else if (cfg_idx_i == CfgWorldsInUse) in_use_q <= cfg_data_i[2:0];
      end
      if (out_v_q && !out_stall_i && state_q != S_OUT) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i && !clearing) state_q <= S_READ;
        S_READ: begin
          found_q <= hit && (it_q.coord_index < 8'(MaxCoords - 1) + 8'd1 || MaxCoords > 255);
          slot_q  <= hslot;
          if (!hit) state_q <= S_WRITE;
          else if (it_q.earlier_samples == '0) begin
            new_q <= '{mean: it_q.sample_value, dev: '0, var_v: '0};
            state_q <= S_WRITE;
          end else state_q <= S_MDIV;
        end
        S_MDIV: state_q <= S_MWAIT;
        S_MWAIT: if (ddone) begin
          new_q.mean <= mean_w[31:0];
          new_q.dev  <= dev_s;
          adev_q     <= dev_s[31] ? 32'(-dev_s) : dev_s;
          state_q    <= S_SQ1;
        end
        S_SQ1: begin
          sq_q <= 64'(adev_q) * 64'(adev_q);
          state_q <= S_SQ2;
        end
        S_SQ2: begin
          term_q   <= sq_q[63:16];
          var_up_q <= sq_q[63:16] >= old_q.var_v;
          state_q  <= S_VDIV;
        end
        S_VDIV: state_q <= S_VWAIT;
        S_VWAIT: if (ddone) begin
          new_q.var_v <= var_up_q ? old_q.var_v + dquo[47:0] : old_q.var_v - dquo[47:0];
          state_q <= S_WRITE;
        end
        S_WRITE: state_q <= S_OUT;
        // hold the new word back until the output register is free
        S_OUT: if (!out_v_q || !out_stall_i) begin
          out_q <= found_q ? '{world_found: 1'b1, mean_out: new_q.mean,
                               deviation_out: new_q.dev, variance_out: new_q.var_v} : '0;
          out_v_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // capture word; store data for its entry arrives during S_MDIV
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && !clearing) it_q <= in_data_i;
    if (state_q == S_MDIV) begin
      old_q <= rdata;
    end
    if (state_q == S_READ) xm_q <= '0;
    if (state_q == S_MDIV) xm_q <= xm_w;
  end

  assign in_stall_o  = !(state_q == S_IDLE && !clearing);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule

// ===== rtl/krmv_checker.sv =====
`timescale 1ns / 1ps
module krmv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input krmv_pkg::out_word_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o)) else $error("held");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.world_found |-> out_data_o.variance_out == '0) else $error("miss");
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("busy");
endmodule

bind keyed_running_mean_variance krmv_checker u_chk (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import krmv_pkg::*;

  localparam int unsigned CfgSlot0 = 0;
  localparam longint      ValMax   = 64'sd2147483647;
  localparam longint      ValMin   = -64'sd2147483648;

  class stats_scoreboard;
    logic [7:0]  slot_id [NumSlots];
    logic [2:0]  in_use;
    longint      mean_mem [Depth];
    longint      dev_mem [Depth];
    logic [63:0] var_mem [Depth];
    out_word_t   expected_q [$];
    int          errors;
    int          checked;
    int          found_cnt;

    function new();
      errors = 0;
      checked = 0;
      found_cnt = 0;
      in_use = '0;
      foreach (slot_id[i]) slot_id[i] = '0;
      foreach (mean_mem[i]) begin
        mean_mem[i] = 0;
        dev_mem[i] = 0;
        var_mem[i] = '0;
      end
    endfunction

    function void write_reg(int unsigned idx, logic [7:0] val);
      if (idx < NumSlots) slot_id[idx] = val;
      else if (idx == CfgWorldsInUse) in_use = val[2:0];
    endfunction

    function longint clamp(longint v);
      if (v > ValMax) return ValMax;
      if (v < ValMin) return ValMin;
      return v;
    endfunction

    // Work out the expected result for an accepted word and update the stores.
    function void note_sample(in_word_t w);
      out_word_t   r;
      int          slot;
      int          lim;
      int          idx;
      longint      x;
      longint      n;
      longint      m;
      longint      d;
      logic [63:0] a;
      logic [63:0] term;
      logic [63:0] old;
      logic [63:0] v;
      r = '0;
      slot = -1;
      lim = (in_use > NumSlots) ? NumSlots : in_use;
      for (int s = 0; s < lim; s++)
        if (slot < 0 && slot_id[s] == w.world_key) slot = s;
      if (slot >= 0 && w.coord_index < MaxCoords) begin
        idx = slot * MaxCoords + w.coord_index;
        x = longint'($signed(w.sample_value));
        n = longint'({40'd0, w.earlier_samples}) + 1;
        if (w.earlier_samples == 0) begin
          m = x;
          d = 0;
          v = '0;
        end else begin
          old = var_mem[idx];
          m = clamp(mean_mem[idx] + (x - mean_mem[idx]) / n);
          d = clamp(x - m);
          a = (d < 0) ? 64'(-d) : 64'(d);
          term = (a * a) >> 16;
          if (term > 64'(VarMax)) term = 64'(VarMax);
          if (term >= old) v = old + (term - old) / 64'(n);
          else v = old - (old - term) / 64'(n);
        end
        mean_mem[idx] = m;
        dev_mem[idx] = d;
        var_mem[idx] = v;
        r.world_found = 1'b1;
        r.mean_out = m[31:0];
        r.deviation_out = d[31:0];
        r.variance_out = v[47:0];
        found_cnt++;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.world_found !== e.world_found) begin
        errors++;
        $display("%0t: world_found exp %0b got %0b", $time, e.world_found, got.world_found);
      end
      if (got.mean_out !== e.mean_out) begin
        errors++;
        $display("%0t: mean_out exp %h got %h", $time, e.mean_out, got.mean_out);
      end
      if (got.deviation_out !== e.deviation_out) begin
        errors++;
        $display("%0t: deviation_out exp %h got %h", $time, e.deviation_out,
                 got.deviation_out);
      end
      if (got.variance_out !== e.variance_out) begin
        errors++;
        $display("%0t: variance_out exp %h got %h", $time, e.variance_out, got.variance_out);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_word_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  stats_scoreboard sb = new();
  bit   long_hold = 1'b0;
  bit   quiet = 1'b0;
  int   sample_cnt [Depth];

  always #2 clk_i = ~clk_i;

  keyed_running_mean_variance u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Receiver: random stalls, quiet stretches, one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        long_hold = 1'b0;
      end
      n = quiet ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(w);
  endtask

  task automatic send_fields(logic [7:0] key, logic [7:0] coord, logic [31:0] x,
                             logic [23:0] cnt);
    in_word_t w;
    w.world_key = key;
    w.coord_index = coord;
    w.sample_value = x;
    w.earlier_samples = cnt;
    send_word(w);
  endtask

  // Drain, let the block settle, then write the table.
  task automatic load_table(logic [7:0] id0, logic [7:0] id1, logic [7:0] id2,
                            logic [7:0] id3, logic [7:0] used);
    logic [7:0] vals [5];
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    vals = '{id0, id1, id2, id3, used};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxW'(CfgSlot0 + i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(i, vals[i]);
    end
    cfg_we_i <= 1'b0;
    foreach (sample_cnt[i]) sample_cnt[i] = 0;
  endtask

  task automatic random_phase(int items);
    logic [7:0]  key;
    logic [7:0]  coord;
    logic [31:0] x;
    logic [23:0] cnt;
    int          slot;
    int          lim;
    int          idx;
    int          r;
    lim = (sb.in_use > NumSlots) ? NumSlots : sb.in_use;
    for (int i = 0; i < items; i++) begin
      if (i == items / 3) long_hold = 1'b1;
      quiet = (i % 100) >= 80;
      r = $urandom_range(0, 99);
      slot = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
      key = (r < 85 && lim > 0) ? sb.slot_id[slot] : 8'($urandom);
      coord = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
      idx = slot * MaxCoords + coord;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        cnt = 24'(sample_cnt[idx]);
        sample_cnt[idx]++;
      end else if (r < 90) begin
        cnt = 24'($urandom);
      end else begin
        cnt = '0;
        sample_cnt[idx] = 1;
      end
      case ($urandom_range(0, 3))
        0: x = $urandom;
        1: x = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        2: x = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: x = 32'($urandom_range(0, 1 << 18)) + 32'h0001_0000;
      endcase
      send_fields(key, coord, x, cnt);
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table after reset: every word misses.
    send_fields(8'd0, 8'd0, 32'h0001_0000, 24'd0);
    load_table(8'd10, 8'd20, 8'd30, 8'd40, 8'd4);
    send_fields(8'd10, 8'd0, 32'h8000_0000, 24'd0);
    send_fields(8'd10, 8'd0, 32'h7FFF_FFFF, 24'd1);
    send_fields(8'd10, 8'd0, 32'h7FFF_FFFF, 24'd2);
    send_fields(8'd20, 8'd255, 32'h7FFF_FFFF, 24'd0);
    send_fields(8'd20, 8'd255, 32'h8000_0000, 24'd1);
    send_fields(8'd20, 8'd255, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_fields(8'd30, 8'd7, 32'h0003_0000, 24'd0);
    send_fields(8'd30, 8'd7, 32'h0005_0000, 24'd1);
    send_fields(8'd30, 8'd7, 32'hFFFE_0000, 24'd2);
    send_fields(8'd40, 8'd128, 32'h0000_0001, 24'd5);
    send_fields(8'd99, 8'd0, 32'h1234_5678, 24'd0);
    send_fields(8'd255, 8'd170, 32'hAAAA_AAAA, 24'hAA_AAAA);
    // Repeated id, and a count above the slot total.
    load_table(8'd0, 8'd255, 8'd255, 8'd7, 8'd7);
    send_fields(8'd255, 8'd85, 32'h5555_5555, 24'h55_5555);
    send_fields(8'd255, 8'd85, 32'h0000_0000, 24'd0);
    send_fields(8'd0, 8'd1, 32'h8000_0000, 24'd0);
    send_fields(8'd7, 8'd1, 32'h4000_0000, 24'd3);
    send_fields(8'd0, 8'd1, 32'h7FFF_FFFF, 24'd1);
    random_phase(250);
    load_table(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    random_phase(60);
    load_table(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'd2);
    random_phase(250);
    load_table(8'd255, 8'd1, 8'd128, 8'd64, 8'd4);
    random_phase(320);

    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.expected_q.size() != 0) sb.errors++;
    $display("Checked %0d results, %0d with a matched world, over five table settings",
             sb.checked, sb.found_cnt);
    $display("including repeated ids, empty and over-full tables and saturating samples");
    if (sb.errors == 0) begin
      $display("keyed_running_mean_variance regression: pass");
    end else begin
      $display("keyed_running_mean_variance regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("keyed_running_mean_variance regression: fail");
    $finish;
  end
endmodule
